### rtl/arc_pkg.sv
// Shared types and constants for the readahead controller.
// Used by every module under rtl/; no dependencies of its own.
package arc_pkg;

  // Buffer size in sectors and the resulting per-read cap (at most 128)
  localparam int BUFFER_SECTORS = 128;
  localparam int CAP_INT        = (BUFFER_SECTORS > 128) ? 128 : BUFFER_SECTORS;
  localparam logic [7:0] CAP_SECTORS = 8'(CAP_INT);

  // Register reset values
  localparam logic [7:0] SMALL_WIN_RST = 8'd4;
  localparam logic [7:0] LARGE_WIN_RST = 8'd128;
  localparam logic [3:0] RETRY_LIM_RST = 4'd5;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_READ_REQ  = 2'd0,
    OP_READ_DONE = 2'd1,
    OP_BATCH     = 2'd2,
    OP_DEV_DONE  = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SMALL_WIN = 2'd0,
    CFG_LARGE_WIN = 2'd1,
    CFG_RETRY_LIM = 2'd2
  } cfg_idx_e;

  // Result kinds
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_RESP = 1'b1;

  // Classified item passed from the front end to the back end
  typedef struct packed {
    op_e         op;
    logic [30:0] sector;       // start sector, sign bit dropped
    logic        reject;       // malformed request, answered with error
    logic [31:0] count;        // batch length
    logic [7:0]  first_chunk;  // first batch chunk, capped
    logic        dev_ok;
  } item_t;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [30:0] cmd_sector;
    logic [7:0]  cmd_count;
    logic        status;
    logic [6:0]  slot;
  } res_t;

endpackage

### rtl/arc_front.sv
// Front end: decodes an incoming item and runs the stateless checks.
// Depends on arc_pkg.
module arc_front (
  input  logic [1:0]          op_i,
  input  logic [31:0]         sector_i,
  input  logic [31:0]         count_i,
  input  logic                dev_ok_i,
  output arc_pkg::item_t      item_o
);

  logic [32:0] batch_end;
  logic        batch_bad;
  logic [7:0]  chunk;

  // Last batch sector plus one must stay within 2^31
  assign batch_end = {2'b00, sector_i[30:0]} + {1'b0, count_i};
  assign batch_bad = (count_i == 32'd0) || sector_i[31] ||
                     (batch_end > 33'h0_8000_0000);

  // First chunk capped at the buffer limit
  assign chunk = (count_i > {24'd0, arc_pkg::CAP_SECTORS}) ? arc_pkg::CAP_SECTORS
                                                          : count_i[7:0];

  always_comb begin
    item_o.op          = arc_pkg::op_e'(op_i);
    item_o.sector      = sector_i[30:0];
    item_o.count       = count_i;
    item_o.first_chunk = chunk;
    item_o.dev_ok      = dev_ok_i;
    case (arc_pkg::op_e'(op_i))
      arc_pkg::OP_READ_REQ: item_o.reject = sector_i[31];
      arc_pkg::OP_BATCH:    item_o.reject = batch_bad;
      default:              item_o.reject = 1'b0;
    endcase
  end

endmodule

### rtl/arc_queue.sv
// Two-entry queue between the front and back ends.
// Depends on arc_pkg for the item type.
module arc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  arc_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output arc_pkg::item_t pop_item_o
);

  arc_pkg::item_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_ready_i && pop_valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### rtl/arc_back.sv
// Back end: window state, retry sequencing, batch chunking and result register.
// Also holds the configuration registers. Depends on arc_pkg.
module arc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  arc_pkg::item_t item_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output arc_pkg::res_t  res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FILL_WIN,
    PH_FILL_ONE,
    PH_BATCH
  } phase_e;

  phase_e        phase_q, phase_d;
  logic          win_valid_q, win_valid_d;
  logic [30:0]   win_start_q, win_start_d;
  logic [7:0]    win_count_q, win_count_d;
  logic          pend_valid_q, pend_valid_d;
  logic [30:0]   pend_q, pend_d;
  logic          ld_valid_q, ld_valid_d;
  logic [30:0]   ld_q, ld_d;
  logic [3:0]    retries_q, retries_d;
  logic [31:0]   req_q, req_d;
  logic [7:0]    infl_q, infl_d;
  logic [31:0]   rem_q, rem_d;
  logic [7:0]    small_q, large_q;
  logic [3:0]    limit_q;
  logic          out_valid_q, out_valid_d;
  arc_pkg::res_t out_q, out_d;

  logic          take;
  logic [31:0]   req_diff, pend_diff;
  logic          req_hit, pend_hit, seq_hit;
  logic [31:0]   batch_next, batch_left;
  logic [7:0]    batch_chunk;
  logic [31:0]   ld_batch;

  function automatic logic [7:0] clamp_win(input logic [7:0] w);
    logic [7:0] r;
    r = w;
    if (w == 8'd0) begin
      r = 8'd1;
    end else if (w > arc_pkg::CAP_SECTORS) begin
      r = arc_pkg::CAP_SECTORS;
    end
    return r;
  endfunction

  function automatic arc_pkg::res_t mk_cmd(input logic [30:0] s, input logic [7:0] c);
    arc_pkg::res_t r;
    r.kind       = arc_pkg::KIND_CMD;
    r.cmd_sector = s;
    r.cmd_count  = c;
    r.status     = 1'b0;
    r.slot       = 7'd0;
    return r;
  endfunction

  function automatic arc_pkg::res_t mk_resp(input logic err, input logic [6:0] slot);
    arc_pkg::res_t r;
    r.kind       = arc_pkg::KIND_RESP;
    r.cmd_sector = 31'd0;
    r.cmd_count  = 8'd0;
    r.status     = err;
    r.slot       = slot;
    return r;
  endfunction

  // An item is taken when the result register is free or being drained
  assign take         = item_valid_i && (!out_valid_q || res_ready_i);
  assign item_ready_o = !out_valid_q || res_ready_i;
  assign res_valid_o  = out_valid_q;
  assign res_o        = out_q;

  // Window lookups: requested sector and pending sector
  assign req_diff  = {1'b0, item_i.sector} - {1'b0, win_start_q};
  assign pend_diff = {1'b0, pend_q} - {1'b0, win_start_q};
  assign req_hit   = win_valid_q && !req_diff[31] &&
                     (req_diff[30:0] < {23'd0, win_count_q});
  assign pend_hit  = win_valid_q && pend_valid_q && !pend_diff[31] &&
                     (pend_diff[30:0] < {23'd0, win_count_q});
  assign seq_hit   = ld_valid_q && ({1'b0, item_i.sector} == ({1'b0, ld_q} + 32'd1));

  // Batch progress after a good chunk
  assign batch_next  = req_q + {24'd0, infl_q};
  assign batch_left  = rem_q - {24'd0, infl_q};
  assign batch_chunk = (batch_left > {24'd0, arc_pkg::CAP_SECTORS}) ? arc_pkg::CAP_SECTORS
                                                                   : batch_left[7:0];
  assign ld_batch    = batch_next - 32'd1;

  // Event handling
  always_comb begin
    phase_d      = phase_q;
    win_valid_d  = win_valid_q;
    win_start_d  = win_start_q;
    win_count_d  = win_count_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    ld_valid_d   = ld_valid_q;
    ld_d         = ld_q;
    retries_d    = retries_q;
    req_d        = req_q;
    infl_d       = infl_q;
    rem_d        = rem_q;
    out_valid_d  = out_valid_q && !res_ready_i;
    out_d        = out_q;

    if (take) begin
      out_valid_d = 1'b1;
      if (item_i.op != arc_pkg::OP_DEV_DONE && phase_q != PH_IDLE) begin
        // busy: refuse without touching state
        out_d = mk_resp(1'b1, 7'd0);
      end else begin
        case (item_i.op)
          arc_pkg::OP_READ_REQ: begin
            if (item_i.reject) begin
              out_d = mk_resp(1'b1, 7'd0);
            end else if (req_hit) begin
              pend_valid_d = 1'b1;
              pend_d       = item_i.sector;
              out_d        = mk_resp(1'b0, 7'd0);
            end else begin
              infl_d    = seq_hit ? clamp_win(large_q) : clamp_win(small_q);
              req_d     = {1'b0, item_i.sector};
              retries_d = limit_q;
              phase_d   = PH_FILL_WIN;
              out_d     = mk_cmd(item_i.sector, infl_d);
            end
          end
          arc_pkg::OP_READ_DONE: begin
            if (pend_hit) begin
              ld_valid_d = 1'b1;
              ld_d       = pend_q;
              out_d      = mk_resp(1'b0, pend_diff[6:0]);
            end else begin
              out_d = mk_resp(1'b1, 7'd0);
            end
          end
          arc_pkg::OP_BATCH: begin
            if (item_i.reject) begin
              out_d = mk_resp(1'b1, 7'd0);
            end else begin
              win_valid_d  = 1'b0;
              win_count_d  = 8'd0;
              pend_valid_d = 1'b0;
              req_d        = {1'b0, item_i.sector};
              rem_d        = item_i.count;
              infl_d       = item_i.first_chunk;
              retries_d    = limit_q;
              phase_d      = PH_BATCH;
              out_d        = mk_cmd(item_i.sector, item_i.first_chunk);
            end
          end
          default: begin
            // device completion
            if (phase_q == PH_IDLE) begin
              out_valid_d = out_valid_q && !res_ready_i;
            end else if (!item_i.dev_ok) begin
              if (retries_q != 4'd0) begin
                retries_d = retries_q - 4'd1;
                out_d     = mk_cmd(req_q[30:0], infl_q);
              end else if (phase_q == PH_FILL_WIN) begin
                infl_d    = 8'd1;
                retries_d = limit_q;
                phase_d   = PH_FILL_ONE;
                out_d     = mk_cmd(req_q[30:0], 8'd1);
              end else begin
                if (phase_q == PH_FILL_ONE) begin
                  win_valid_d  = 1'b0;
                  win_count_d  = 8'd0;
                  pend_valid_d = 1'b0;
                end
                rem_d   = 32'd0;
                phase_d = PH_IDLE;
                out_d   = mk_resp(1'b1, 7'd0);
              end
            end else if (phase_q == PH_BATCH) begin
              req_d = batch_next;
              rem_d = batch_left;
              if (batch_left == 32'd0) begin
                ld_valid_d = 1'b1;
                ld_d       = ld_batch[30:0];
                phase_d    = PH_IDLE;
                out_d      = mk_resp(1'b0, 7'd0);
              end else begin
                infl_d    = batch_chunk;
                retries_d = limit_q;
                out_d     = mk_cmd(batch_next[30:0], batch_chunk);
              end
            end else begin
              // window or single-sector fill landed
              win_valid_d  = 1'b1;
              win_start_d  = req_q[30:0];
              win_count_d  = infl_q;
              pend_valid_d = 1'b1;
              pend_d       = req_q[30:0];
              phase_d      = PH_IDLE;
              out_d        = mk_resp(1'b0, 7'd0);
            end
          end
        endcase
      end
    end
  end

  // Control state, sector values, result register and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      win_valid_q  <= 1'b0;
      win_start_q  <= 31'd0;
      win_count_q  <= 8'd0;
      pend_valid_q <= 1'b0;
      pend_q       <= 31'd0;
      ld_valid_q   <= 1'b0;
      ld_q         <= 31'd0;
      retries_q    <= 4'd0;
      req_q        <= 32'd0;
      infl_q       <= 8'd0;
      rem_q        <= 32'd0;
      small_q      <= arc_pkg::SMALL_WIN_RST;
      large_q      <= arc_pkg::LARGE_WIN_RST;
      limit_q      <= arc_pkg::RETRY_LIM_RST;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      win_valid_q  <= win_valid_d;
      win_start_q  <= win_start_d;
      win_count_q  <= win_count_d;
      pend_valid_q <= pend_valid_d;
      pend_q       <= pend_d;
      ld_valid_q   <= ld_valid_d;
      ld_q         <= ld_d;
      retries_q    <= retries_d;
      req_q        <= req_d;
      infl_q       <= infl_d;
      rem_q        <= rem_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
      if (cfg_we_i) begin
        case (arc_pkg::cfg_idx_e'(cfg_idx_i))
          arc_pkg::CFG_SMALL_WIN: small_q <= cfg_data_i;
          arc_pkg::CFG_LARGE_WIN: large_q <= cfg_data_i;
          arc_pkg::CFG_RETRY_LIM: limit_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/adaptive_readahead_controller_unit.sv
// Readahead controller top level: front-end checks, item queue, back-end state.
// Depends on arc_pkg, arc_front, arc_queue and arc_back.
//
// Accepts one item per clock while the queue has room and delivers at most one
// result per item, in order. The front end decodes the item and checks negative
// sectors and batch bounds; a two-entry queue decouples it from the back end,
// which holds the window and retry state and retires one item per cycle into a
// result register while that register is free or being drained. An item passes
// through a queue entry and then the result register when nothing stalls. A device
// completion while idle produces no result. Configuration writes take effect at
// once and should be made only while the block is idle.
module adaptive_readahead_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // sector[31:0], count[63:32], device_ok[64], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // cmd_sector[30:0], cmd_count[38:31], status[39],
                                      // buffer_slot[46:40], zero pad
  output logic        m_axis_tuser    // kind
);

  arc_pkg::item_t front_item, back_item;
  arc_pkg::res_t  res;
  logic           back_valid, back_ready;

  // Decode and stateless checks
  arc_front u_front (
    .op_i     (s_axis_tuser),
    .sector_i (s_axis_tdata[31:0]),
    .count_i  (s_axis_tdata[63:32]),
    .dev_ok_i (s_axis_tdata[64]),
    .item_o   (front_item)
  );

  // Decoupling queue
  arc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  // Window state and result register
  arc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .item_i       (back_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {1'b0, res.slot, res.status, res.cmd_count, res.cmd_sector};
  assign m_axis_tuser = res.kind;

endmodule
